// File: hdl/ght_pkg.sv
// shared types and constants for the generational handle table
`timescale 1ns / 1ps
`default_nettype none

package ght_pkg;

    localparam int DEFAULT_SLOTS = 1024;

    localparam int MODE_W   = 2;
    localparam int OBJ_W    = 32;
    localparam int FLAGS_W  = 8;
    localparam int SN_W     = 10;
    localparam int STATUS_W = 2;
    localparam int GEN_W    = 32;
    localparam int LIVE_W   = 11;

    localparam logic [OBJ_W-1:0] OBJ_NONE  = '1;
    localparam logic [GEN_W-1:0] GEN_FIRST = GEN_W'(1);

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_REMOVE = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

endpackage

`default_nettype wire

// File: hdl/ght_slot_ram.sv
// single-port-write, single-port-read slot memory with registered read data
`timescale 1ns / 1ps
`default_nettype none

module ght_slot_ram
    import ght_pkg::*;
#(
    parameter int DEPTH  = DEFAULT_SLOTS,
    parameter int ADDR_W = $clog2(DEFAULT_SLOTS),
    parameter int DATA_W = 73 + $clog2(DEFAULT_SLOTS)
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hdl/generational_handle_table.sv
// generational handle table: slot memory, free list and occupancy control
//
//  channel | signals                                             | direction
//  --------+-----------------------------------------------------+----------
//  in      | in_valid, in_stall, mode, object_index,             | request in
//          | access_flags, slot_number                           |
//  out     | out_valid, out_stall, status, slot_result,          | result out
//          | generation_out, object_out, flags_out, live_count   |
//
//  each request goes through the slot memory read and then the
//  read-modify-write with the result registered
//  one request at a time; a new request is taken while the last result waits
//  a result that is stalled holds the request in its read-modify-write step
//  reset clears the free list, fresh counter and used count, not live_count;
//  slots at or above the fresh counter read as empty, so no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module generational_handle_table
    import ght_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [MODE_W-1:0]   mode,
    input  wire logic [OBJ_W-1:0]    object_index,
    input  wire logic [FLAGS_W-1:0]  access_flags,
    input  wire logic [SN_W-1:0]     slot_number,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [SN_W-1:0]          slot_result,
    output logic [GEN_W-1:0]         generation_out,
    output logic [OBJ_W-1:0]         object_out,
    output logic [FLAGS_W-1:0]       flags_out,
    output logic [LIVE_W-1:0]        live_count
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    // memory word: valid, object, flags, generation, free link
    localparam int L_GEN   = SW;
    localparam int L_FLAGS = L_GEN + GEN_W;
    localparam int L_OBJ   = L_FLAGS + FLAGS_W;
    localparam int L_VALID = L_OBJ + OBJ_W;
    localparam int WORD_W  = L_VALID + 1;

    localparam logic [31:0] SLOTS_32 = 32'(SLOTS);
    localparam logic [CW-1:0] SLOTS_CW = CW'(SLOTS);

    state_t state_reg, state_next;

    logic [MODE_W-1:0]  req_mode_reg;
    logic [OBJ_W-1:0]   req_obj_reg;
    logic [FLAGS_W-1:0] req_flags_reg;
    logic [SN_W-1:0]    req_sn_reg;

    logic          free_nonempty_reg, free_nonempty_next;
    logic [SW-1:0] free_head_reg, free_head_next;
    logic [CW-1:0] fresh_next_reg, fresh_next_next;
    logic [CW-1:0] used_count_reg, used_count_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SN_W-1:0]     slot_result_reg, slot_result_next;
    logic [GEN_W-1:0]    gen_out_reg, gen_out_next;
    logic [OBJ_W-1:0]    obj_out_reg, obj_out_next;
    logic [FLAGS_W-1:0]  flags_out_reg, flags_out_next;
    logic [LIVE_W-1:0]   live_reg;

    logic accept;
    logic commit;

    logic              ram_rd_en;
    logic [SW-1:0]     ram_rd_addr;
    logic [WORD_W-1:0] ram_rd_data;
    logic              ram_wr_en;
    logic [SW-1:0]     ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;

    logic               rd_valid;
    logic [OBJ_W-1:0]   rd_obj;
    logic [FLAGS_W-1:0] rd_flags;
    logic [GEN_W-1:0]   rd_gen;
    logic [SW-1:0]      rd_link;

    logic          sn_in_range;
    logic [SW-1:0] sn_addr;
    logic          occupied;
    logic          table_full;
    logic [GEN_W-1:0] new_gen;

    ght_slot_ram #(
        .DEPTH  (SLOTS),
        .ADDR_W (SW),
        .DATA_W (WORD_W)
    ) u_slot_ram (
        .clk     (clk),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    // ---------------- control ----------------

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        accept   = 1'b0;
        commit   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                accept   = in_valid;
            end
            S_EXEC:
            begin
                commit = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // insert reads the free-list head, the others read the named slot
    assign ram_rd_en   = accept;
    assign ram_rd_addr = (mode_t'(mode) == MODE_INSERT) ? free_head_reg : SW'(slot_number);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            free_nonempty_reg <= 1'b0;
            free_head_reg     <= '0;
            fresh_next_reg    <= '0;
            used_count_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                free_nonempty_reg <= free_nonempty_next;
                free_head_reg     <= free_head_next;
                fresh_next_reg    <= fresh_next_next;
                used_count_reg    <= used_count_next;
                out_valid_reg     <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_mode_reg  <= mode;
            req_obj_reg   <= object_index;
            req_flags_reg <= access_flags;
            req_sn_reg    <= slot_number;
        end
        if (commit)
        begin
            status_reg      <= status_next;
            slot_result_reg <= slot_result_next;
            gen_out_reg     <= gen_out_next;
            obj_out_reg     <= obj_out_next;
            flags_out_reg   <= flags_out_next;
            live_reg        <= LIVE_W'(used_count_next);
        end
    end

    // ---------------- read-modify-write ----------------

    assign rd_valid = ram_rd_data[L_VALID];
    assign rd_obj   = ram_rd_data[L_OBJ +: OBJ_W];
    assign rd_flags = ram_rd_data[L_FLAGS +: FLAGS_W];
    assign rd_gen   = ram_rd_data[L_GEN +: GEN_W];
    assign rd_link  = ram_rd_data[SW-1:0];

    assign sn_in_range = {{(32 - SN_W){1'b0}}, req_sn_reg} < SLOTS_32;
    assign sn_addr     = SW'(req_sn_reg);
    // slots at or above the fresh counter have never been written
    assign occupied    = sn_in_range && (CW'(req_sn_reg) < fresh_next_reg) && rd_valid;
    assign table_full  = !free_nonempty_reg && (fresh_next_reg == SLOTS_CW);
    assign new_gen     = rd_gen + GEN_W'(1);

    always_comb
    begin
        free_nonempty_next = free_nonempty_reg;
        free_head_next     = free_head_reg;
        fresh_next_next    = fresh_next_reg;
        used_count_next    = used_count_reg;
        status_next        = ST_INVALID;
        slot_result_next   = req_sn_reg;
        gen_out_next       = '0;
        obj_out_next       = '0;
        flags_out_next     = '0;
        ram_wr_en          = 1'b0;
        ram_wr_addr        = sn_addr;
        ram_wr_data        = '0;
        case (mode_t'(req_mode_reg))
            MODE_INSERT:
            begin
                slot_result_next = '0;
                if (req_obj_reg == OBJ_NONE)
                begin
                    status_next = ST_INVALID;
                end
                else if (table_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next     = ST_OK;
                    used_count_next = used_count_reg + CW'(1);
                    ram_wr_en       = commit;
                    if (free_nonempty_reg)
                    begin
                        // a self link marks the bottom of the free list
                        if (rd_link != free_head_reg)
                        begin
                            free_head_next = rd_link;
                        end
                        else
                        begin
                            free_nonempty_next = 1'b0;
                        end
                        ram_wr_addr      = free_head_reg;
                        ram_wr_data      = {1'b1, req_obj_reg, req_flags_reg, rd_gen, rd_link};
                        slot_result_next = SN_W'(free_head_reg);
                        gen_out_next     = rd_gen;
                    end
                    else
                    begin
                        fresh_next_next  = fresh_next_reg + CW'(1);
                        ram_wr_addr      = SW'(fresh_next_reg);
                        ram_wr_data      = {1'b1, req_obj_reg, req_flags_reg, GEN_FIRST,
                                            {SW{1'b0}}};
                        slot_result_next = SN_W'(fresh_next_reg);
                        gen_out_next     = GEN_FIRST;
                    end
                end
            end
            MODE_LOOKUP:
            begin
                if (occupied)
                begin
                    status_next    = ST_OK;
                    gen_out_next   = rd_gen;
                    obj_out_next   = rd_obj;
                    flags_out_next = rd_flags;
                end
            end
            MODE_REMOVE:
            begin
                if (occupied)
                begin
                    status_next        = ST_OK;
                    used_count_next    = used_count_reg - CW'(1);
                    free_head_next     = sn_addr;
                    free_nonempty_next = 1'b1;
                    ram_wr_en          = commit;
                    ram_wr_data        = {1'b0, OBJ_NONE, {FLAGS_W{1'b0}}, new_gen,
                                          free_nonempty_reg ? free_head_reg : sn_addr};
                end
            end
            default:
            begin
                status_next = ST_INVALID;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign slot_result    = slot_result_reg;
    assign generation_out = gen_out_reg;
    assign object_out     = obj_out_reg;
    assign flags_out      = flags_out_reg;
    assign live_count     = live_reg;

    // ---------------- assertions ----------------

    a_count_below_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg <= fresh_next_reg)
        else $error("live count exceeds slots ever handed out");

    a_fresh_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_next_reg <= SLOTS_CW)
        else $error("fresh counter ran past the table");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result appeared without a request in progress");

    a_count_moves_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (used_count_reg != $past(used_count_reg)) |-> $past(commit))
        else $error("live count changed outside a commit");

endmodule

`default_nettype wire

// File: tb/generational_handle_table_test.sv
// testbench for the generational handle table: predicted results checked in order
`timescale 1ns / 1ps

module generational_handle_table_test;
    import ght_pkg::*;

    localparam int SLOTS        = DEFAULT_SLOTS;
    localparam int ITEMS        = 1550;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;

    // mode code that the block does not define
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef enum int {
        PH_MIX,
        PH_FILL,
        PH_DRAIN
    } load_phase_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SN_W-1:0]     slot;
        logic [GEN_W-1:0]    gen;
        logic [OBJ_W-1:0]    obj;
        logic [FLAGS_W-1:0]  flags;
        logic [LIVE_W-1:0]   live;
    } handle_result_t;

    class handle_ledger;
        bit                 slot_taken[SLOTS];
        logic [OBJ_W-1:0]   slot_obj[SLOTS];
        logic [FLAGS_W-1:0] slot_flg[SLOTS];
        logic [GEN_W-1:0]   slot_gen[SLOTS];
        logic [SN_W-1:0]    chain_link[SLOTS];
        bit                 free_nonempty;
        logic [SN_W-1:0]    free_top;
        int                 fresh_next;
        int                 used_count;
        int                 occupied[$];
        int                 full_count;
        int                 failures;
        handle_result_t     owed_results[$];

        function void note_request(logic [MODE_W-1:0] m, logic [OBJ_W-1:0] obj,
                                   logic [FLAGS_W-1:0] flg, logic [SN_W-1:0] sn);
            handle_result_t r;
            int s;
            r = '0;
            r.status = ST_INVALID;
            r.slot = sn;
            case (m)
                MODE_INSERT:
                begin
                    r.slot = '0;
                    if (obj == OBJ_NONE)
                    begin
                        r.status = ST_INVALID;
                    end
                    else if (!free_nonempty && fresh_next >= SLOTS)
                    begin
                        r.status = ST_FULL;
                        full_count++;
                    end
                    else
                    begin
                        if (free_nonempty)
                        begin
                            s = int'(free_top);
                            // a self link marks the bottom of the free list
                            if (chain_link[s] != SN_W'(s))
                                free_top = chain_link[s];
                            else
                                free_nonempty = 1'b0;
                        end
                        else
                        begin
                            s = fresh_next;
                            fresh_next++;
                            slot_gen[s] = GEN_FIRST;
                        end
                        slot_taken[s] = 1'b1;
                        slot_obj[s] = obj;
                        slot_flg[s] = flg;
                        used_count++;
                        occupied.push_back(s);
                        r.status = ST_OK;
                        r.slot = SN_W'(s);
                        r.gen = slot_gen[s];
                    end
                end
                MODE_LOOKUP:
                begin
                    if (slot_taken[sn])
                    begin
                        r.status = ST_OK;
                        r.gen = slot_gen[sn];
                        r.obj = slot_obj[sn];
                        r.flags = slot_flg[sn];
                    end
                end
                MODE_REMOVE:
                begin
                    if (slot_taken[sn])
                    begin
                        slot_taken[sn] = 1'b0;
                        slot_obj[sn] = OBJ_NONE;
                        slot_flg[sn] = '0;
                        slot_gen[sn] = slot_gen[sn] + GEN_W'(1);
                        chain_link[sn] = free_nonempty ? free_top : sn;
                        free_top = sn;
                        free_nonempty = 1'b1;
                        used_count--;
                        foreach (occupied[i])
                        begin
                            if (occupied[i] == int'(sn))
                            begin
                                occupied.delete(i);
                                break;
                            end
                        end
                        r.status = ST_OK;
                    end
                end
                default: ;
            endcase
            r.live = LIVE_W'(used_count);
            owed_results.push_back(r);
        endfunction

        function void check_result(handle_result_t got);
            handle_result_t want;
            if (owed_results.size() == 0)
            begin
                $error("result with nothing outstanding: status %0d slot %0d",
                       got.status, got.slot);
                failures++;
                return;
            end
            want = owed_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                failures++;
            end
            if (got.slot !== want.slot)
            begin
                $error("slot_result: expected %0d, got %0d", want.slot, got.slot);
                failures++;
            end
            if (got.gen !== want.gen)
            begin
                $error("generation_out: expected %h, got %h", want.gen, got.gen);
                failures++;
            end
            if (got.obj !== want.obj)
            begin
                $error("object_out: expected %h, got %h", want.obj, got.obj);
                failures++;
            end
            if (got.flags !== want.flags)
            begin
                $error("flags_out: expected %h, got %h", want.flags, got.flags);
                failures++;
            end
            if (got.live !== want.live)
            begin
                $error("live_count: expected %0d, got %0d", want.live, got.live);
                failures++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [MODE_W-1:0]   mode = MODE_LOOKUP;
    logic [OBJ_W-1:0]    object_index = '0;
    logic [FLAGS_W-1:0]  access_flags = '0;
    logic [SN_W-1:0]     slot_number = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [SN_W-1:0]     slot_result;
    logic [GEN_W-1:0]    generation_out;
    logic [OBJ_W-1:0]    object_out;
    logic [FLAGS_W-1:0]  flags_out;
    logic [LIVE_W-1:0]   live_count;

    handle_ledger ledger = new;
    int requests_sent = 0;
    int burst_left = 0;
    bit hold_wanted = 1'b0;

    generational_handle_table #(
        .SLOTS(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .object_index(object_index),
        .access_flags(access_flags),
        .slot_number(slot_number),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .slot_result(slot_result),
        .generation_out(generation_out),
        .object_out(object_out),
        .flags_out(flags_out),
        .live_count(live_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic send_request(input logic [MODE_W-1:0] m, input logic [OBJ_W-1:0] obj,
                                input logic [FLAGS_W-1:0] flg, input logic [SN_W-1:0] sn);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
            burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 16);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        mode <= m;
        object_index <= obj;
        access_flags <= flg;
        slot_number <= sn;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ledger.note_request(m, obj, flg, sn);
        requests_sent++;
        if (requests_sent == HOLD_AT)
            hold_wanted = 1'b1;
    endtask

    // mostly slots that hold a handle, otherwise anything in range
    function automatic logic [SN_W-1:0] pick_slot();
        int n;
        n = ledger.occupied.size();
        if (n > 0 && $urandom_range(0, 3) != 0)
            return SN_W'(ledger.occupied[$urandom_range(0, n - 1)]);
        return SN_W'($urandom_range(0, SLOTS - 1));
    endfunction

    task automatic random_request(input load_phase_t ph);
        int roll;
        logic [MODE_W-1:0] m;
        logic [OBJ_W-1:0] obj;
        roll = $urandom_range(0, 99);
        case (ph)
            PH_FILL:
                m = roll < 94 ? MODE_INSERT : roll < 98 ? MODE_LOOKUP :
                    roll < 99 ? MODE_REMOVE : MODE_SPARE;
            PH_DRAIN:
                m = roll < 55 ? MODE_REMOVE : roll < 70 ? MODE_INSERT :
                    roll < 95 ? MODE_LOOKUP : MODE_SPARE;
            default:
                m = roll < 40 ? MODE_INSERT : roll < 68 ? MODE_LOOKUP :
                    roll < 95 ? MODE_REMOVE : MODE_SPARE;
        endcase
        obj = $urandom;
        case ($urandom_range(0, 19))
            0: obj = OBJ_NONE;
            1: obj = '0;
            2: obj = OBJ_NONE - OBJ_W'(1);
            default: ;
        endcase
        send_request(m, obj, FLAGS_W'($urandom), pick_slot());
    endtask

    // result side: check, then pick the next stall from a changing pattern
    initial
    begin : result_side
        handle_result_t got;
        int hold_left;
        int pattern;
        int pattern_left;
        bit hold_done;
        bit next_stall;
        hold_left = 0;
        pattern = 0;
        pattern_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = {status, slot_result, generation_out, object_out, flags_out, live_count};
                ledger.check_result(got);
            end
            if (hold_wanted && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (pattern_left == 0)
            begin
                pattern = $urandom_range(0, 3);
                pattern_left = $urandom_range(20, 80);
            end
            pattern_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                next_stall = 1'b1;
            end
            else
            begin
                case (pattern)
                    1: next_stall = ($urandom_range(0, 3) == 0);
                    2: next_stall = ($urandom_range(0, 3) != 0);
                    3: next_stall = ~out_stall;
                    default: next_stall = 1'b0;
                endcase
            end
            out_stall <= next_stall;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, unused mode, rejected none object
        send_request(MODE_LOOKUP, '0, '0, '0);
        send_request(MODE_REMOVE, '0, '0, SN_W'(SLOTS - 1));
        send_request(MODE_SPARE, '0, '0, SN_W'(SLOTS - 1));
        send_request(MODE_INSERT, OBJ_NONE, '1, '0);
        // fresh slots, extreme objects and flags
        send_request(MODE_INSERT, '0, '0, '1);
        send_request(MODE_INSERT, OBJ_NONE - OBJ_W'(1), '1, '0);
        send_request(MODE_LOOKUP, '0, '0, SN_W'(0));
        send_request(MODE_LOOKUP, '1, '1, SN_W'(1));
        send_request(MODE_LOOKUP, '0, '0, SN_W'(SLOTS - 1));
        // remove, stale lookup, double remove, reuse with next generation
        send_request(MODE_REMOVE, '0, '0, SN_W'(0));
        send_request(MODE_LOOKUP, '0, '0, SN_W'(0));
        send_request(MODE_REMOVE, '0, '0, SN_W'(0));
        send_request(MODE_INSERT, 32'h5555_aaaa, 8'h5a, '0);
        // free list order is last removed first
        send_request(MODE_REMOVE, '0, '0, SN_W'(1));
        send_request(MODE_REMOVE, '0, '0, SN_W'(0));
        send_request(MODE_INSERT, 32'haaaa_5555, 8'ha5, '0);
        send_request(MODE_INSERT, 32'h0000_0001, 8'h01, '0);
        send_request(MODE_INSERT, 32'h8000_0000, 8'h80, '0);
        send_request(MODE_LOOKUP, '0, '0, SN_W'(2));
        send_request(MODE_SPARE, '1, '1, '0);

        for (int i = 0; i < 150; i++)
            random_request(PH_MIX);
        // fill to the last slot and keep asking past full
        while (ledger.full_count < 12 && requests_sent < 1450)
            random_request(PH_FILL);
        while (requests_sent < ITEMS)
            random_request(PH_DRAIN);
        in_valid <= 1'b0;

        while (ledger.owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ledger.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
